@@ sv/ebga_pkg.sv @@
// Shared types, constants and helper functions for the eye blink and gaze animator.
// Used by the serial multiplier, the serial divider and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ebga_pkg;

  // Configuration port.
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegBlinkMs    = 8'd0;
  localparam logic [CfgIdxW-1:0] RegLookMs     = 8'd1;
  localparam logic [CfgIdxW-1:0] RegIdleMinMs  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegIdleRandMs = 8'd3;
  localparam logic [CfgIdxW-1:0] RegLidShut    = 8'd4;
  localparam logic [CfgIdxW-1:0] RegGazeMaxX   = 8'd5;
  localparam logic [CfgIdxW-1:0] RegGazeMaxY   = 8'd6;

  // Register reset values.
  localparam logic [15:0] BlinkMsRst    = 16'd260;
  localparam logic [15:0] LookMsRst     = 16'd220;
  localparam logic [15:0] IdleMinMsRst  = 16'd2200;
  localparam logic [15:0] IdleRandMsRst = 16'd3001;
  localparam logic [15:0] LidShutRst    = 16'd60293;
  localparam logic [6:0]  GazeMaxRst    = 7'd8;

  // Number of expressions; codes at or above it leave the expression unchanged.
  localparam int ExprCount = 16;

  // Highest valid gaze direction code.
  localparam logic [3:0] GazeLast = 4'd8;

  // Serial arithmetic unit widths.
  localparam int MulAW    = 32;
  localparam int MulBW    = 17;
  localparam int MulPW    = MulAW + MulBW;
  localparam int MulCntW  = $clog2(MulBW + 1);
  localparam int DivRemW  = 49;
  localparam int DivBitsW = 32;
  localparam int DivCntW  = $clog2(DivBitsW + 1);

  // Multiplier request: operands latched on start.
  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  // Divider request: partial remainder to start from, numerator bits
  // left aligned, number of quotient bits to develop and the divisor.
  typedef struct packed {
    logic                start;
    logic [DivRemW-1:0]  rem_init;
    logic [DivBitsW-1:0] bits;
    logic [DivCntW-1:0]  iters;
    logic [DivRemW-1:0]  den;
  } div_req_t;

  // Horizontal unit step of a direction: -1, 0 or +1 as {neg, pos}.
  function automatic logic [1:0] unit_x(input logic [3:0] dir);
    logic [1:0] u;
    case (dir)
      4'd3, 4'd5, 4'd7: u = 2'b10;
      4'd4, 4'd6, 4'd8: u = 2'b01;
      default:          u = 2'b00;
    endcase
    return u;
  endfunction

  // Vertical unit step of a direction: -1, 0 or +1 as {neg, pos}.
  function automatic logic [1:0] unit_y(input logic [3:0] dir);
    logic [1:0] u;
    case (dir)
      4'd1, 4'd5, 4'd6: u = 2'b10;
      4'd2, 4'd7, 4'd8: u = 2'b01;
      default:          u = 2'b00;
    endcase
    return u;
  endfunction

  // Target position in Q8.8 for a unit step and a maximum offset.
  function automatic logic signed [15:0] gaze_target(input logic [1:0] u,
                                                     input logic [6:0] max_px);
    logic [15:0] v;
    v = {1'b0, max_px, 8'd0};
    if (u[1]) begin
      return -v;
    end else if (u[0]) begin
      return v;
    end
    return 16'sd0;
  endfunction

  // Q8.8 position to whole pixels, rounded half away from zero.
  function automatic logic [7:0] to_pixel(input logic signed [15:0] p);
    logic        neg;
    logic [16:0] mag;
    logic [16:0] sum;
    neg = p[15];
    mag = neg ? 17'(-{p[15], p}) : {1'b0, p};
    sum = mag + 17'd128;
    return neg ? 8'(-sum[15:8]) : sum[15:8];
  endfunction

endpackage
`default_nettype wire

@@ sv/ebga_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ebga_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none
module ebga_mul (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ebga_pkg::mul_req_t       req_i,
  output logic                          done_o,
  output logic [ebga_pkg::MulPW-1:0]    prod_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [ebga_pkg::MulCntW-1:0]  cnt_q;
  logic [ebga_pkg::MulPW-1:0]    a_q;
  logic [ebga_pkg::MulBW-1:0]    b_q;
  logic [ebga_pkg::MulPW-1:0]    acc_q;

  // Control: run for one step per multiplier bit, then pulse done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ebga_pkg::MulCntW'(ebga_pkg::MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the multiplicand shifts left, the multiplier shifts right.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= {{ebga_pkg::MulBW{1'b0}}, req_i.a};
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[ebga_pkg::MulPW-2:0], 1'b0};
      b_q <= {1'b0, b_q[ebga_pkg::MulBW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

@@ sv/ebga_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on ebga_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none
module ebga_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ebga_pkg::div_req_t         req_i,
  output logic                            done_o,
  output logic [ebga_pkg::DivBitsW-1:0]   quo_o,
  output logic [ebga_pkg::DivRemW-1:0]    rem_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [ebga_pkg::DivCntW-1:0]   cnt_q;
  logic [ebga_pkg::DivRemW-1:0]   rem_q;
  logic [ebga_pkg::DivBitsW-1:0]  bits_q;
  logic [ebga_pkg::DivBitsW-1:0]  quo_q;
  logic [ebga_pkg::DivRemW-1:0]   den_q;
  logic [ebga_pkg::DivRemW:0]     trial;
  logic                           fits;

  // One step: bring down the next numerator bit and try a subtraction.
  assign trial = {rem_q, bits_q[ebga_pkg::DivBitsW-1]};
  assign fits  = trial >= {1'b0, den_q};

  // Control: count down the requested number of quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ebga_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, numerator shift line and quotient shift line.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      bits_q <= req_i.bits;
      quo_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      rem_q  <= fits ? ebga_pkg::DivRemW'(trial - {1'b0, den_q})
                     : trial[ebga_pkg::DivRemW-1:0];
      bits_q <= {bits_q[ebga_pkg::DivBitsW-2:0], 1'b0};
      quo_q  <= {quo_q[ebga_pkg::DivBitsW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ sv/eye_blink_gaze_animator_unit.sv @@
// Eye blink and gaze animator: one result transaction per frame transaction.
// Each frame carries the time in ms, the wanted expression and gaze direction,
// a blink request and a random word. The result gives the lid openness (Q1.15),
// the shown expression, the pupil offsets in pixels and the blinking flag.
// Configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the block is idle, which
// the block itself does not enforce; unknown indexes are ignored.
// One frame is processed at a time. The work runs on one bit-serial
// multiplier (17 shift steps per product) and one bit-serial divider (one
// quotient bit per cycle), used in turn. A frame's work ranges from the idle
// modulus and the two pupil products (no blink in progress, no easing; no
// modulus when idle_rand_ms is zero) up to the idle modulus, lid and ease
// divisions and seven products. The next frame can be accepted in the same
// cycle as the result is offered. The result sits in an output register; the
// next frame is accepted while it waits. If the receiver stalls, the following
// frame completes its work and then holds until the output register frees up.
// Reset restores the configuration registers to their documented values,
// clears the animation state and leaves no result pending.
// Depends on ebga_pkg, ebga_mul and ebga_div.
`timescale 1ns / 1ps
`default_nettype none
module eye_blink_gaze_animator_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration writes.
  input  wire logic                         cfg_we_i,
  input  wire logic [ebga_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ebga_pkg::CfgDataW-1:0] cfg_data_i,
  // Frame input.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [31:0]                  now_ms_i,
  input  wire logic [3:0]                   target_expr_i,
  input  wire logic [3:0]                   target_gaze_i,
  input  wire logic                         blink_request_i,
  input  wire logic [31:0]                  random_word_i,
  // Result output.
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [15:0]                       lid_open_o,
  output logic [3:0]                        shown_expression_o,
  output logic signed [7:0]                 pupil_x_o,
  output logic signed [7:0]                 pupil_y_o,
  output logic                              blinking_o
);

  // Sequencer states.
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SMod   = 4'd1;
  localparam logic [3:0] SBlink = 4'd2;
  localparam logic [3:0] SLMul  = 4'd3;
  localparam logic [3:0] SLDiv  = 4'd4;
  localparam logic [3:0] SRSq   = 4'd5;
  localparam logic [3:0] SRCu   = 4'd6;
  localparam logic [3:0] SLSq   = 4'd7;
  localparam logic [3:0] SLCu   = 4'd8;
  localparam logic [3:0] SEDiv  = 4'd9;
  localparam logic [3:0] SXMul  = 4'd10;
  localparam logic [3:0] SYMul  = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;

  // Configuration registers.
  logic [15:0] blink_ms_q, look_ms_q, idle_min_q, idle_rand_q, lid_shut_q;
  logic [6:0]  gaze_max_x_q, gaze_max_y_q;

  // Animation state.
  logic               has_started_q, blink_active_q, swap_done_q;
  logic [31:0]        blink_start_q, next_idle_q, ease_start_q;
  logic [3:0]         cur_expr_q, cur_dir_q;
  logic signed [15:0] from_x_q, from_y_q, to_x_q, to_y_q, pos_x_q, pos_y_q;

  // Sequencer and work registers.
  logic [3:0]  state_q;
  logic        run_q;
  logic [31:0] now_q, rnd_q;
  logic [3:0]  expr_q, gaze_q;
  logic        req_q;
  logic [15:0] extra_q;
  logic [15:0] x_q, r_q, lid_q;
  logic        ease_run_q;
  logic [31:0] sq_q;
  logic [47:0] prod_q, r3_q, l3_q;
  logic [16:0] e_q;

  // Output register.
  logic        out_valid_q;
  logic [15:0] lid_out_q;
  logic [3:0]  expr_out_q;
  logic [7:0]  px_q, py_q;
  logic        blinking_out_q;

  // Serial units.
  ebga_pkg::mul_req_t            mul_req;
  ebga_pkg::div_req_t            div_req;
  logic                          mul_done, div_done;
  logic [ebga_pkg::MulPW-1:0]    mul_prod;
  logic [ebga_pkg::DivBitsW-1:0] div_quo;
  logic [ebga_pkg::DivRemW-1:0]  div_rem;

  ebga_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  ebga_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // Frame-level blink and gaze decisions, evaluated in the blink step.
  logic [3:0]         expr_eff;
  logic [16:0]        delay;
  logic [31:0]        fresh_idle, nit, due_diff, bst_n, d, dt, est_n;
  logic               due, start_blink, active_n, swap_n, blink_end, mid, lid_need;
  logic [15:0]        x_n;
  logic               dir_change, ease_run;
  logic signed [15:0] from_x_n, from_y_n;

  always_comb begin
    expr_eff    = (32'(expr_q) >= 32'(ebga_pkg::ExprCount)) ? cur_expr_q : expr_q;
    delay       = {1'b0, idle_min_q} + {1'b0, extra_q};
    fresh_idle  = now_q + {15'd0, delay};
    nit         = has_started_q ? next_idle_q : fresh_idle;
    due_diff    = now_q - nit;
    due         = !due_diff[31];
    start_blink = !blink_active_q && ((expr_eff != cur_expr_q) || req_q || due);
    active_n    = blink_active_q || start_blink;
    swap_n      = start_blink ? 1'b0 : swap_done_q;
    bst_n       = start_blink ? now_q : blink_start_q;
    d           = now_q - bst_n;
    blink_end   = active_n && (d >= {16'd0, blink_ms_q});
    mid         = {d[15:0], 1'b0} >= {1'b0, blink_ms_q};
    lid_need    = active_n && !blink_end;
    x_n         = mid ? (blink_ms_q - d[15:0]) : d[15:0];
    dir_change  = (gaze_q <= ebga_pkg::GazeLast) && (gaze_q != cur_dir_q);
    est_n       = dir_change ? now_q : ease_start_q;
    dt          = now_q - est_n;
    ease_run    = dt < {16'd0, look_ms_q};
    from_x_n    = dir_change ? pos_x_q : from_x_q;
    from_y_n    = dir_change ? pos_y_q : from_y_q;
  end

  // Per-axis easing: difference magnitude and signed correction.
  logic signed [16:0] diff_x, diff_y;
  logic [16:0]        mag_x, mag_y;
  logic [33:0]        round_p;
  logic [15:0]        step_mag;

  assign diff_x   = 17'(to_x_q) - 17'(from_x_q);
  assign diff_y   = 17'(to_y_q) - 17'(from_y_q);
  assign mag_x    = diff_x[16] ? 17'(-diff_x) : diff_x;
  assign mag_y    = diff_y[16] ? 17'(-diff_y) : diff_y;
  assign round_p  = mul_prod[33:0] + 34'd32768;
  assign step_mag = round_p[31:16];

  // Rounded quotients of the lid and ease divisions.
  logic        lid_up, ease_up;
  logic [16:0] lid_q17, ease_q17;

  assign lid_up   = {div_rem[15:0], 1'b0} >= {1'b0, blink_ms_q};
  assign ease_up  = {div_rem[47:0], 1'b0} >= {1'b0, l3_q};
  assign lid_q17  = div_quo[16:0] + {16'd0, lid_up};
  assign ease_q17 = div_quo[16:0] + {16'd0, ease_up};

  // Operand selection for the shared multiplier.
  logic mul_state;
  always_comb begin
    mul_state = 1'b1;
    mul_req.a = '0;
    mul_req.b = '0;
    case (state_q)
      SLMul: begin
        mul_req.a = {16'd0, lid_shut_q};
        mul_req.b = {1'b0, x_q};
      end
      SRSq: begin
        mul_req.a = {16'd0, r_q};
        mul_req.b = {1'b0, r_q};
      end
      SRCu: begin
        mul_req.a = sq_q;
        mul_req.b = {1'b0, r_q};
      end
      SLSq: begin
        mul_req.a = {16'd0, look_ms_q};
        mul_req.b = {1'b0, look_ms_q};
      end
      SLCu: begin
        mul_req.a = sq_q;
        mul_req.b = {1'b0, look_ms_q};
      end
      SXMul: begin
        mul_req.a = {15'd0, mag_x};
        mul_req.b = e_q;
      end
      SYMul: begin
        mul_req.a = {15'd0, mag_y};
        mul_req.b = e_q;
      end
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !run_q;
  end

  // Operand selection for the shared divider.
  logic div_state;
  always_comb begin
    div_state        = 1'b1;
    div_req.rem_init = '0;
    div_req.bits     = '0;
    div_req.iters    = '0;
    div_req.den      = '0;
    case (state_q)
      SMod: begin
        div_req.bits  = rnd_q;
        div_req.iters = ebga_pkg::DivCntW'(32);
        div_req.den   = {33'd0, idle_rand_q};
        div_state     = (idle_rand_q != 16'd0);
      end
      SLDiv: begin
        div_req.rem_init = {34'd0, prod_q[31:17]};
        div_req.bits     = {prod_q[16:0], 15'd0};
        div_req.iters    = ebga_pkg::DivCntW'(17);
        div_req.den      = {33'd0, blink_ms_q};
      end
      SEDiv: begin
        div_req.rem_init = {2'd0, r3_q[47:1]};
        div_req.bits     = {r3_q[0], 31'd0};
        div_req.iters    = ebga_pkg::DivCntW'(17);
        div_req.den      = {1'b0, l3_q};
      end
      default: div_state = 1'b0;
    endcase
    div_req.start = div_state && !run_q;
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ms_q   <= ebga_pkg::BlinkMsRst;
      look_ms_q    <= ebga_pkg::LookMsRst;
      idle_min_q   <= ebga_pkg::IdleMinMsRst;
      idle_rand_q  <= ebga_pkg::IdleRandMsRst;
      lid_shut_q   <= ebga_pkg::LidShutRst;
      gaze_max_x_q <= ebga_pkg::GazeMaxRst;
      gaze_max_y_q <= ebga_pkg::GazeMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ebga_pkg::RegBlinkMs:    blink_ms_q   <= cfg_data_i;
        ebga_pkg::RegLookMs:     look_ms_q    <= cfg_data_i;
        ebga_pkg::RegIdleMinMs:  idle_min_q   <= cfg_data_i;
        ebga_pkg::RegIdleRandMs: idle_rand_q  <= cfg_data_i;
        ebga_pkg::RegLidShut:    lid_shut_q   <= cfg_data_i;
        ebga_pkg::RegGazeMaxX:   gaze_max_x_q <= cfg_data_i[6:0];
        ebga_pkg::RegGazeMaxY:   gaze_max_y_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer and animation state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      run_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      has_started_q  <= 1'b0;
      blink_active_q <= 1'b0;
      swap_done_q    <= 1'b0;
      blink_start_q  <= '0;
      next_idle_q    <= '0;
      ease_start_q   <= '0;
      cur_expr_q     <= '0;
      cur_dir_q      <= '0;
      from_x_q       <= '0;
      from_y_q       <= '0;
      to_x_q         <= '0;
      to_y_q         <= '0;
      pos_x_q        <= '0;
      pos_y_q        <= '0;
    end else begin
      // A result taken while no new one is loaded frees the output register.
      if (out_valid_q && out_ready_i && (state_q != SOut)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            state_q <= SMod;
          end
        end
        SMod: begin
          if (idle_rand_q == 16'd0) begin
            state_q <= SBlink;
          end else if (!run_q) begin
            run_q <= 1'b1;
          end else if (div_done) begin
            run_q   <= 1'b0;
            state_q <= SBlink;
          end
        end
        SBlink: begin
          has_started_q  <= 1'b1;
          blink_start_q  <= bst_n;
          next_idle_q    <= blink_end ? fresh_idle : nit;
          blink_active_q <= lid_need;
          swap_done_q    <= swap_n || (lid_need && mid);
          if ((blink_end && !swap_n) || (lid_need && mid && !swap_n)) begin
            cur_expr_q <= expr_eff;
          end
          if (dir_change) begin
            cur_dir_q    <= gaze_q;
            from_x_q     <= from_x_n;
            from_y_q     <= from_y_n;
            to_x_q       <= ebga_pkg::gaze_target(ebga_pkg::unit_x(gaze_q), gaze_max_x_q);
            to_y_q       <= ebga_pkg::gaze_target(ebga_pkg::unit_y(gaze_q), gaze_max_y_q);
            ease_start_q <= now_q;
          end
          if (lid_need) begin
            state_q <= SLMul;
          end else if (ease_run) begin
            state_q <= SRSq;
          end else begin
            state_q <= SXMul;
          end
        end
        SLMul, SRSq, SRCu, SLSq, SLCu: begin
          if (!run_q) begin
            run_q <= 1'b1;
          end else if (mul_done) begin
            run_q   <= 1'b0;
            state_q <= state_q + 4'd1;
          end
        end
        SLDiv: begin
          if (!run_q) begin
            run_q <= 1'b1;
          end else if (div_done) begin
            run_q   <= 1'b0;
            state_q <= ease_run_q ? SRSq : SXMul;
          end
        end
        SEDiv: begin
          if (!run_q) begin
            run_q <= 1'b1;
          end else if (div_done) begin
            run_q   <= 1'b0;
            state_q <= SXMul;
          end
        end
        SXMul: begin
          if (!run_q) begin
            run_q <= 1'b1;
          end else if (mul_done) begin
            run_q   <= 1'b0;
            pos_x_q <= from_x_q + (diff_x[16] ? -step_mag : step_mag);
            state_q <= SYMul;
          end
        end
        SYMul: begin
          if (!run_q) begin
            run_q <= 1'b1;
          end else if (mul_done) begin
            run_q   <= 1'b0;
            pos_y_q <= from_y_q + (diff_y[16] ? -step_mag : step_mag);
            state_q <= SOut;
          end
        end
        SOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // Work registers and the output payload.
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          now_q   <= now_ms_i;
          expr_q  <= target_expr_i;
          gaze_q  <= target_gaze_i;
          req_q   <= blink_request_i;
          rnd_q   <= random_word_i;
          extra_q <= '0;
        end
      end
      SMod: begin
        if (div_done) begin
          extra_q <= div_rem[15:0];
        end
      end
      SBlink: begin
        x_q        <= x_n;
        r_q        <= look_ms_q - dt[15:0];
        ease_run_q <= ease_run;
        lid_q      <= 16'd32768;
        e_q        <= 17'h10000;
      end
      SLMul: begin
        if (mul_done) prod_q <= mul_prod[47:0];
      end
      SLDiv: begin
        if (div_done) lid_q <= 16'(17'h08000 - lid_q17);
      end
      SRSq, SLSq: begin
        if (mul_done) sq_q <= mul_prod[31:0];
      end
      SRCu: begin
        if (mul_done) r3_q <= mul_prod[47:0];
      end
      SLCu: begin
        if (mul_done) l3_q <= mul_prod[47:0];
      end
      SEDiv: begin
        if (div_done) e_q <= 17'h10000 - ease_q17;
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          lid_out_q      <= lid_q;
          expr_out_q     <= cur_expr_q;
          px_q           <= ebga_pkg::to_pixel(pos_x_q);
          py_q           <= ebga_pkg::to_pixel(pos_y_q);
          blinking_out_q <= blink_active_q;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o         = (state_q == SIdle);
  assign out_valid_o        = out_valid_q;
  assign lid_open_o         = lid_out_q;
  assign shown_expression_o = expr_out_q;
  assign pupil_x_o          = px_q;
  assign pupil_y_o          = py_q;
  assign blinking_o         = blinking_out_q;

endmodule
`default_nettype wire

@@ sim/ebga_frame_checker.sv @@
// Scoreboard for the eye blink and gaze animator: predicts each result from the
// accepted frame transactions and compares it with the block's output.
// Depends on ebga_pkg for register indexes, reset values and port widths.
`timescale 1ns / 1ps
module ebga_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ebga_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ebga_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [3:0]                   target_expr_i,
  input  logic [3:0]                   target_gaze_i,
  input  logic                         blink_request_i,
  input  logic [31:0]                  random_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [15:0]                  lid_open_i,
  input  logic [3:0]                   shown_expression_i,
  input  logic [7:0]                   pupil_x_i,
  input  logic [7:0]                   pupil_y_i,
  input  logic                         blinking_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import ebga_pkg::*;

  typedef struct packed {
    logic [15:0] lid;
    logic [3:0]  expr;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        blink;
  } eye_frame_t;

  eye_frame_t eye_frames_due[$];

  // Register copies.
  logic [15:0] blink_ms, look_ms, idle_min, idle_rand, lid_shut;
  logic [6:0]  max_x, max_y;

  // Animation state.
  logic        started, in_blink, swapped;
  logic [31:0] blink_t0, idle_deadline, ease_t0;
  logic [3:0]  expr_q, dir_q;
  longint      from_x, from_y, to_x, to_y, pos_x, pos_y;

  function automatic longint div_round_away(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (2 * mag + den) / (2 * den);
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] idle_delay(logic [31:0] rnd);
    logic [31:0] extra;
    extra = (idle_rand != 0) ? rnd % 32'(idle_rand) : 32'd0;
    return 32'(idle_min) + extra;
  endfunction

  function automatic longint unit_step_x(logic [3:0] dir);
    case (dir)
      4'd3, 4'd5, 4'd7: return -1;
      4'd4, 4'd6, 4'd8: return 1;
      default:          return 0;
    endcase
  endfunction

  function automatic longint unit_step_y(logic [3:0] dir);
    case (dir)
      4'd1, 4'd5, 4'd6: return -1;
      4'd2, 4'd7, 4'd8: return 1;
      default:          return 0;
    endcase
  endfunction

  // Advance the animation by one frame and return the expected output.
  function automatic eye_frame_t animate_frame(logic [31:0] now, logic [3:0] tgt_expr,
                                               logic [3:0] tgt_gaze, logic req,
                                               logic [31:0] rnd);
    eye_frame_t  r;
    logic [31:0] d, dt, due_diff;
    logic [63:0] b, x, rr, l, num, den, q;
    longint      e;
    logic [3:0]  want;
    r.lid = 16'd32768;
    want = (int'(tgt_expr) >= ExprCount) ? expr_q : tgt_expr;
    if (!started) begin
      started = 1'b1;
      idle_deadline = now + idle_delay(rnd);
    end
    if (!in_blink) begin
      due_diff = now - idle_deadline;
      if (want != expr_q || req || !due_diff[31]) begin
        in_blink = 1'b1;
        swapped = 1'b0;
        blink_t0 = now;
      end
    end
    if (in_blink) begin
      d = now - blink_t0;
      if (d >= 32'(blink_ms)) begin
        if (!swapped) expr_q = want;
        in_blink = 1'b0;
        idle_deadline = now + idle_delay(rnd);
      end else begin
        b = 64'(blink_ms);
        if (2 * 64'(d) >= b) begin
          if (!swapped) begin
            expr_q = want;
            swapped = 1'b1;
          end
          x = b - 64'(d);
        end else begin
          x = 64'(d);
        end
        r.lid = 16'(32'd32768 - 32'((2 * 64'(lid_shut) * x + b) / (2 * b)));
      end
    end
    // Gaze easing.
    if (tgt_gaze <= GazeLast && tgt_gaze != dir_q) begin
      dir_q = tgt_gaze;
      from_x = pos_x;
      from_y = pos_y;
      to_x = unit_step_x(tgt_gaze) * longint'(max_x) * 256;
      to_y = unit_step_y(tgt_gaze) * longint'(max_y) * 256;
      ease_t0 = now;
    end
    dt = now - ease_t0;
    e = 65536;
    if (dt < 32'(look_ms)) begin
      rr = 64'(look_ms) - 64'(dt);
      l = 64'(look_ms);
      num = rr * rr * rr * 64'd65536;
      den = l * l * l;
      q = num / den;
      if (2 * (num % den) >= den) q++;
      e = 65536 - longint'(q);
    end
    pos_x = from_x + div_round_away((to_x - from_x) * e, 65536);
    pos_y = from_y + div_round_away((to_y - from_y) * e, 65536);
    r.expr = expr_q;
    r.px = 8'(div_round_away(pos_x, 256));
    r.py = 8'(div_round_away(pos_y, 256));
    r.blink = in_blink;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    eye_frame_t want;
    if (!rst_ni) begin
      blink_ms = BlinkMsRst; look_ms = LookMsRst; idle_min = IdleMinMsRst;
      idle_rand = IdleRandMsRst; lid_shut = LidShutRst;
      max_x = GazeMaxRst; max_y = GazeMaxRst;
      started = 1'b0; in_blink = 1'b0; swapped = 1'b0;
      blink_t0 = '0; idle_deadline = '0; ease_t0 = '0;
      expr_q = '0; dir_q = '0;
      from_x = 0; from_y = 0; to_x = 0; to_y = 0; pos_x = 0; pos_y = 0;
      eye_frames_due.delete();
      fail_count_o = 0;
    end else begin
      // Register writes; unknown indexes fall through.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBlinkMs:    blink_ms = cfg_data_i;
          RegLookMs:     look_ms = cfg_data_i;
          RegIdleMinMs:  idle_min = cfg_data_i;
          RegIdleRandMs: idle_rand = cfg_data_i;
          RegLidShut:    lid_shut = cfg_data_i;
          RegGazeMaxX:   max_x = cfg_data_i[6:0];
          RegGazeMaxY:   max_y = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        eye_frames_due.push_back(animate_frame(now_ms_i, target_expr_i, target_gaze_i,
                                               blink_request_i, random_word_i));
      end
      // Compare each result transaction with the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (eye_frames_due.size() == 0) begin
          $display("%0t: result transaction with no frame outstanding", $realtime);
          fail_count_o++;
        end else begin
          want = eye_frames_due.pop_front();
          if (lid_open_i !== want.lid) report_mismatch("lid_open", lid_open_i, want.lid);
          if (shown_expression_i !== want.expr)
            report_mismatch("shown_expression", shown_expression_i, want.expr);
          if (pupil_x_i !== want.px)
            report_mismatch("pupil_x", $signed(pupil_x_i), $signed(want.px));
          if (pupil_y_i !== want.py)
            report_mismatch("pupil_y", $signed(pupil_y_i), $signed(want.py));
          if (blinking_i !== want.blink) report_mismatch("blinking", blinking_i, want.blink);
        end
      end
    end
    pending_o = eye_frames_due.size();
  end
endmodule

@@ sim/eye_blink_gaze_animator_unit_tb.sv @@
// Top of the animator testbench: clock, reset, frame and register stimulus,
// receiver stalls, watchdog and verdict.
// Depends on ebga_pkg, eye_blink_gaze_animator_unit and ebga_frame_checker.
`timescale 1ns / 1ps
module eye_blink_gaze_animator_unit_tb;
  import ebga_pkg::*;

  localparam int StallLimit = 20000;
  localparam int DrainCycles = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [31:0]         now_ms_i = '0;
  logic [3:0]          target_expr_i = '0;
  logic [3:0]          target_gaze_i = '0;
  logic                blink_request_i = 1'b0;
  logic [31:0]         random_word_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [15:0]         lid_open_o;
  logic [3:0]          shown_expression_o;
  logic signed [7:0]   pupil_x_o;
  logic signed [7:0]   pupil_y_o;
  logic                blinking_o;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;
  logic [31:0]         clock_ms;
  logic [3:0]          expr_held;
  logic [3:0]          gaze_held;

  always #5 clk_i = ~clk_i;

  eye_blink_gaze_animator_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .now_ms_i, .target_expr_i, .target_gaze_i,
    .blink_request_i, .random_word_i,
    .out_valid_o, .out_ready_i, .lid_open_o, .shown_expression_o,
    .pupil_x_o, .pupil_y_o, .blinking_o
  );

  ebga_frame_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .now_ms_i, .target_expr_i, .target_gaze_i,
    .blink_request_i, .random_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .lid_open_i(lid_open_o),
    .shown_expression_i(shown_expression_o), .pupil_x_i(pupil_x_o),
    .pupil_y_i(pupil_y_o), .blinking_i(blinking_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 3);
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one frame and hold it until the transaction completes; the caller's
  // gap choice decides whether valid drops afterwards.
  task automatic send_frame(logic [31:0] now, logic [3:0] expr, logic [3:0] gaze,
                            logic req, logic [31:0] rnd, bit with_gaps);
    int gap;
    in_valid_i <= 1'b1;
    now_ms_i <= now;
    target_expr_i <= expr;
    target_gaze_i <= gaze;
    blink_request_i <= req;
    random_word_i <= rnd;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    gap = with_gaps ? gap_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Withdraw the last frame right after its transaction, then let the block drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [15:0] blink, logic [15:0] look, logic [15:0] imin,
                                logic [15:0] irand, logic [15:0] shut, logic [6:0] gx,
                                logic [6:0] gy);
    write_reg(RegBlinkMs, blink);
    write_reg(RegLookMs, look);
    write_reg(RegIdleMinMs, imin);
    write_reg(RegIdleRandMs, irand);
    write_reg(RegLidShut, shut);
    write_reg(RegGazeMaxX, {9'h1ff, gx});
    write_reg(RegGazeMaxY, {9'h0aa, gy});
  endtask

  // Mostly steady frames with small time steps; some changes, jumps and noise.
  task automatic random_frames(int count, int step_max);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) clock_ms += $urandom_range(1, step_max);
      else if (sel < 90) clock_ms += $urandom_range(0, 20 * step_max);
      else if (sel < 95) clock_ms += $urandom;
      if ($urandom_range(0, 9) == 0) expr_held = 4'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 12) gaze_held = 4'($urandom_range(0, 8));
      else if (sel < 16) gaze_held = 4'($urandom_range(9, 15));
      send_frame(clock_ms, expr_held, gaze_held, $urandom_range(0, 19) == 0, $urandom,
                 (k / 100) % 3 != 1);
    end
  endtask

  // Stimulus.
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed frames at reset settings, starting just before the time wraps.
    clock_ms = 32'hffff_ff80;
    send_frame(clock_ms, 4'd0, 4'd0, 1'b0, 32'hffff_ffff, 1'b1);
    for (int g = 1; g <= 8; g++) begin
      clock_ms += 7;
      send_frame(clock_ms, 4'd0, 4'(g), 1'b0, 32'h0, 1'b1);
    end
    clock_ms += 10;
    send_frame(clock_ms, 4'd15, 4'd15, 1'b0, 32'h0, 1'b1);
    clock_ms += 40;
    send_frame(clock_ms, 4'd15, 4'd0, 1'b1, 32'h8000_0000, 1'b1);
    for (int k = 0; k < 5; k++) begin
      clock_ms += 60;
      send_frame(clock_ms, 4'd15, 4'd8, k[0], 32'h5555_aaaa, 1'b1);
    end
    clock_ms += 32'h7fff_ffff;
    send_frame(clock_ms, 4'd15, 4'd8, 1'b0, 32'h0, 1'b1);
    clock_ms += 32'h8000_0001;
    send_frame(clock_ms, 4'd9, 4'd2, 1'b0, 32'hffff_ffff, 1'b1);
    clock_ms += 300;
    send_frame(clock_ms, 4'd9, 4'd2, 1'b0, 32'h1234_5678, 1'b1);
    expr_held = 4'd9;
    gaze_held = 4'd2;
    random_frames(300, 40);
    wait_idle();
    // Fastest animation, deepest lid, widest gaze; unknown index ignored.
    apply_settings(16'd1, 16'd1, 16'd0, 16'd1, 16'hffff, 7'd127, 7'd127);
    write_reg(8'd7, 16'd5);
    write_reg(8'hff, 16'hffff);
    random_frames(300, 3);
    wait_idle();
    // Slowest animation, no lid travel, no gaze travel.
    apply_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 7'd0, 7'd0);
    random_frames(150, 2000);
    wait_idle();
    apply_settings(16'($urandom_range(20, 600)), 16'($urandom_range(20, 600)),
                   16'($urandom_range(0, 500)), 16'($urandom_range(1, 2000)),
                   16'($urandom), 7'($urandom), 7'($urandom));
    random_frames(300, 40);
    wait_idle();
    apply_settings(16'd260, 16'd220, 16'd100, 16'd400, 16'd32768, 7'd64, 7'd1);
    random_frames(250, 30);
    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("eye_blink_gaze_animator_unit_tb passed");
    end else begin
      $display("eye_blink_gaze_animator_unit_tb failed");
    end
    $finish;
  end

  // Receiver: random stalls in bursts, plus one long hold-off to back up the input.
  initial begin
    int cycle;
    int burst;
    bit stalls_on;
    cycle = 0;
    burst = 0;
    stalls_on = 1'b1;
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle == 30000) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
      end
      if (burst == 0) begin
        burst = 500;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      burst--;
      if (!stalls_on) out_ready_i <= 1'b1;
      else if ($urandom_range(0, 29) == 0) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 2) == 0) out_ready_i <= ~out_ready_i;
      else if (!out_ready_i && $urandom_range(0, 9) == 0) out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("eye_blink_gaze_animator_unit_tb failed");
        $finish;
      end
    end
  end
endmodule
